// ----- src/gpff_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gpff_pkg
// Shared types and constants for the gray palette fog fader: opcodes,
// register indexes, state encodings and the palette index wrap table.
// ----------------------------------------------------------------------------
package gpff_pkg;

    // Palette depth and index width
    localparam int ENTRIES = 256;
    localparam int IDX_W   = $clog2(ENTRIES);

    // Field widths
    localparam int COLOR_W  = 8;
    localparam int LEVEL_W  = 8;
    localparam int OFFSET_W = 10;
    localparam int STEP_W   = 8;
    localparam int LIMIT_W  = 9;
    localparam int OPCODE_W = 2;

    // Configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Tick arithmetic runs one bit wider than the offset
    localparam int SUM_W = OFFSET_W + 1;
    localparam logic signed [SUM_W-1:0] LEVEL_MAX = SUM_W'(255);

    // Reset values of the configuration registers
    localparam logic [STEP_W-1:0]         FOG_STEP_RST = STEP_W'(4);
    localparam logic signed [LIMIT_W-1:0] UPPER_RST    = LIMIT_W'(64);
    localparam logic signed [LIMIT_W-1:0] LOWER_RST    = -LIMIT_W'(64);

    // Gray conversion: squares, their sum, divide by three, root
    localparam int SQ_W   = 2 * COLOR_W;
    localparam int SSUM_W = SQ_W + 2;
    localparam int DIV3_SHIFT = 19;
    localparam logic [SSUM_W-1:0] RECIP3 = SSUM_W'(((1 << DIV3_SHIFT) + 2) / 3);
    localparam int ROOT_W = LEVEL_W;
    localparam int BIT_W  = $clog2(ROOT_W);

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD = 2'd0,
        OP_TICK = 2'd1,
        OP_READ = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        REG_FOG_STEP    = 2'd0,
        REG_UPPER_LIMIT = 2'd1,
        REG_LOWER_LIMIT = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_LOAD,
        FS_TICK,
        FS_READ,
        FS_EMIT
    } fader_state_t;

    typedef enum logic [2:0] {
        GS_IDLE,
        GS_SQUARE,
        GS_SUM,
        GS_DIV,
        GS_ROOT,
        GS_DONE
    } gray_state_t;

    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] level;
    } gray_result_t;

    // Entry index wrap, worked out at elaboration
    typedef logic [IDX_W-1:0] idx_table_t [256];

    function automatic idx_table_t build_idx_table();
        idx_table_t t;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = IDX_W'(i % ENTRIES);
        end
        return t;
    endfunction

    localparam idx_table_t IDX_TABLE = build_idx_table();

endpackage
`default_nettype wire

// ----- src/gpff_cmd_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gpff_cmd_if
// Command channel: opcode, palette index and the colour of a load.
// ----------------------------------------------------------------------------
interface gpff_cmd_if;
    logic                             valid;
    logic                             ready;
    logic [gpff_pkg::OPCODE_W-1:0]    opcode;
    logic [7:0]                       entry_index;
    logic [gpff_pkg::COLOR_W-1:0]     red_in;
    logic [gpff_pkg::COLOR_W-1:0]     green_in;
    logic [gpff_pkg::COLOR_W-1:0]     blue_in;

    modport source (
        output valid, opcode, entry_index, red_in, green_in, blue_in,
        input  ready
    );

    modport sink (
        input  valid, opcode, entry_index, red_in, green_in, blue_in,
        output ready
    );
endinterface
`default_nettype wire

// ----- src/gpff_rsp_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gpff_rsp_if
// Response channel: gray level and the brightness offset after the item.
// ----------------------------------------------------------------------------
interface gpff_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [gpff_pkg::LEVEL_W-1:0]        level_out;
    logic signed [gpff_pkg::OFFSET_W-1:0] offset_out;

    modport source (
        output valid, level_out, offset_out,
        input  ready
    );

    modport sink (
        input  valid, level_out, offset_out,
        output ready
    );
endinterface
`default_nettype wire

// ----- src/gpff_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gpff_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gpff_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- src/gpff_gray_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gpff_gray_unit
// Multi-cycle RGB to gray conversion: floor(sqrt(floor((r*r+g*g+b*b)/3))).
// Squares, sum, reciprocal multiply, then one root bit per cycle.
// ----------------------------------------------------------------------------
module gpff_gray_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [gpff_pkg::COLOR_W-1:0]   red,
    input  wire logic [gpff_pkg::COLOR_W-1:0]   green,
    input  wire logic [gpff_pkg::COLOR_W-1:0]   blue,
    output gpff_pkg::gray_result_t              result
);

    localparam int PROD_W = 2 * gpff_pkg::SSUM_W;
    localparam int QUOT_W = gpff_pkg::SQ_W;

    gpff_pkg::gray_state_t state_reg, state_next;

    logic [gpff_pkg::COLOR_W-1:0] red_reg, green_reg, blue_reg;
    logic [gpff_pkg::SQ_W-1:0]    sq_r_reg, sq_g_reg, sq_b_reg;
    logic [gpff_pkg::SSUM_W-1:0]  sum_reg;
    logic [QUOT_W-1:0]            quot_reg;
    logic [gpff_pkg::ROOT_W-1:0]  root_reg;
    logic [gpff_pkg::BIT_W-1:0]   bit_reg;

    logic [PROD_W-1:0]            prod;
    logic [gpff_pkg::ROOT_W-1:0]  trial;
    logic [QUOT_W-1:0]            trial_sq;

    assign prod     = PROD_W'(sum_reg) * PROD_W'(gpff_pkg::RECIP3);
    assign trial    = root_reg | (gpff_pkg::ROOT_W'(1) << bit_reg);
    assign trial_sq = QUOT_W'(trial) * QUOT_W'(trial);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gpff_pkg::GS_IDLE:
            begin
                if (start)
                begin
                    state_next = gpff_pkg::GS_SQUARE;
                end
            end
            gpff_pkg::GS_SQUARE: state_next = gpff_pkg::GS_SUM;
            gpff_pkg::GS_SUM:    state_next = gpff_pkg::GS_DIV;
            gpff_pkg::GS_DIV:    state_next = gpff_pkg::GS_ROOT;
            gpff_pkg::GS_ROOT:
            begin
                if (bit_reg == '0)
                begin
                    state_next = gpff_pkg::GS_DONE;
                end
            end
            gpff_pkg::GS_DONE:   state_next = gpff_pkg::GS_IDLE;
            default:             state_next = gpff_pkg::GS_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        result.done  = (state_reg == gpff_pkg::GS_DONE);
        result.level = root_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gpff_pkg::GS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            gpff_pkg::GS_IDLE:
            begin
                red_reg   <= red;
                green_reg <= green;
                blue_reg  <= blue;
            end
            gpff_pkg::GS_SQUARE:
            begin
                sq_r_reg <= gpff_pkg::SQ_W'(red_reg)   * gpff_pkg::SQ_W'(red_reg);
                sq_g_reg <= gpff_pkg::SQ_W'(green_reg) * gpff_pkg::SQ_W'(green_reg);
                sq_b_reg <= gpff_pkg::SQ_W'(blue_reg)  * gpff_pkg::SQ_W'(blue_reg);
            end
            gpff_pkg::GS_SUM:
            begin
                sum_reg <= gpff_pkg::SSUM_W'(sq_r_reg) + gpff_pkg::SSUM_W'(sq_g_reg)
                         + gpff_pkg::SSUM_W'(sq_b_reg);
            end
            gpff_pkg::GS_DIV:
            begin
                // Exact floor divide by three for every sum below 2^19
                quot_reg <= prod[gpff_pkg::DIV3_SHIFT +: QUOT_W];
                root_reg <= '0;
                bit_reg  <= gpff_pkg::BIT_W'(gpff_pkg::ROOT_W - 1);
            end
            gpff_pkg::GS_ROOT:
            begin
                // Keep the trial bit when its square still fits
                if (trial_sq <= quot_reg)
                begin
                    root_reg <= trial;
                end
                bit_reg <= bit_reg - gpff_pkg::BIT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- src/gray_palette_fog_fader_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gray_palette_fog_fader_unit
// Gray palette with a bouncing brightness offset, top level.
// ----------------------------------------------------------------------------
// Commands arrive on cmd as valid/ready transactions: load stores the gray
// level of an RGB colour in a palette entry, tick moves the brightness offset
// by fog_step and bounces it between the two limits, read returns the stored
// gray plus the offset, saturated to 0..255. Each command yields exactly one
// response transaction on rsp carrying the level and the offset after it.
// Registers fog_step, offset_upper_limit and offset_lower_limit are written
// through the APB port at byte addresses 0, 4 and 8.
// One command is in flight at a time. A load waits for the eight-step root
// unit before the next accept. Tick and read step through their own state to
// emit; a read takes the entry from the registered read of the palette RAM.
// The response sits in an output register: when rsp stalls, the block holds
// the finished result and waits before loading the next one.
// Reset clears the offset to zero, turns the direction downward and loads
// the register defaults; palette entries are undefined until loaded.
// ----------------------------------------------------------------------------
module gray_palette_fog_fader_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    gpff_cmd_if.sink                              cmd,
    gpff_rsp_if.source                            rsp,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [gpff_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [gpff_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [gpff_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready
);

    localparam int SW = gpff_pkg::SUM_W;

    gpff_pkg::fader_state_t state_reg, state_next;

    logic [gpff_pkg::STEP_W-1:0]          step_reg;
    logic signed [gpff_pkg::LIMIT_W-1:0]  upper_reg;
    logic signed [gpff_pkg::LIMIT_W-1:0]  lower_reg;

    logic signed [gpff_pkg::OFFSET_W-1:0] offset_reg, offset_next;
    logic                                 moving_down_reg, moving_down_next;
    logic [gpff_pkg::LEVEL_W-1:0]         level_reg, level_next;
    logic [gpff_pkg::IDX_W-1:0]           idx_reg;

    logic                                 rsp_valid_reg;
    logic [gpff_pkg::LEVEL_W-1:0]         rsp_level_reg;
    logic signed [gpff_pkg::OFFSET_W-1:0] rsp_offset_reg;

    logic                                 cmd_fire;
    logic                                 rsp_free;
    logic                                 rsp_load;
    logic                                 gray_start;
    logic                                 ram_we;
    logic [gpff_pkg::LEVEL_W-1:0]         ram_rdata;
    gpff_pkg::gray_result_t               gray;
    gpff_pkg::opcode_t                    opcode;
    logic                                 cfg_write;

    logic signed [SW-1:0]                 tick_sum;
    logic signed [SW-1:0]                 tick_clamped;
    logic                                 tick_down;
    logic signed [SW-1:0]                 read_sum;
    logic [gpff_pkg::LEVEL_W-1:0]         read_level;

    assign opcode   = gpff_pkg::opcode_t'(cmd.opcode);
    assign cmd_fire = cmd.valid && cmd.ready;
    assign rsp_free = !rsp_valid_reg || rsp.ready;

    // ------------------------------------------------------------------------
    // Palette store and gray converter
    // ------------------------------------------------------------------------
    gpff_ram #(
        .WIDTH (gpff_pkg::LEVEL_W),
        .DEPTH (gpff_pkg::ENTRIES)
    ) u_palette (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (idx_reg),
        .wr_data (gray.level),
        .re      (cmd_fire),
        .rd_addr (gpff_pkg::IDX_TABLE[cmd.entry_index]),
        .rd_data (ram_rdata)
    );

    gpff_gray_unit u_gray (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (gray_start),
        .red    (cmd.red_in),
        .green  (cmd.green_in),
        .blue   (cmd.blue_in),
        .result (gray)
    );

    // ------------------------------------------------------------------------
    // Tick and read arithmetic
    // ------------------------------------------------------------------------
    always_comb
    begin
        if (moving_down_reg)
        begin
            tick_sum = SW'(offset_reg) - $signed({3'b000, step_reg});
        end
        else
        begin
            tick_sum = SW'(offset_reg) + $signed({3'b000, step_reg});
        end
        tick_clamped = tick_sum;
        tick_down    = moving_down_reg;
        // Upper test first, lower test wins when the limits cross
        if (tick_clamped > SW'(upper_reg))
        begin
            tick_clamped = SW'(upper_reg);
            tick_down    = 1'b1;
        end
        if (tick_clamped < SW'(lower_reg))
        begin
            tick_clamped = SW'(lower_reg);
            tick_down    = 1'b0;
        end
    end

    always_comb
    begin
        read_sum = $signed({3'b000, ram_rdata}) + SW'(offset_reg);
        priority if (read_sum > gpff_pkg::LEVEL_MAX)
        begin
            read_level = gpff_pkg::LEVEL_W'(gpff_pkg::LEVEL_MAX);
        end
        else if (read_sum < 0)
        begin
            read_level = '0;
        end
        else
        begin
            read_level = read_sum[gpff_pkg::LEVEL_W-1:0];
        end
    end

    // ------------------------------------------------------------------------
    // Control: next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gpff_pkg::FS_IDLE:
            begin
                if (cmd_fire)
                begin
                    unique case (opcode)
                        gpff_pkg::OP_LOAD: state_next = gpff_pkg::FS_LOAD;
                        gpff_pkg::OP_TICK: state_next = gpff_pkg::FS_TICK;
                        gpff_pkg::OP_READ: state_next = gpff_pkg::FS_READ;
                        default:           state_next = gpff_pkg::FS_EMIT;
                    endcase
                end
            end
            gpff_pkg::FS_LOAD:
            begin
                if (gray.done)
                begin
                    state_next = gpff_pkg::FS_EMIT;
                end
            end
            gpff_pkg::FS_TICK: state_next = gpff_pkg::FS_EMIT;
            gpff_pkg::FS_READ: state_next = gpff_pkg::FS_EMIT;
            gpff_pkg::FS_EMIT:
            begin
                if (rsp_free)
                begin
                    state_next = gpff_pkg::FS_IDLE;
                end
            end
            default: state_next = gpff_pkg::FS_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // Control: outputs and datapath updates
    // ------------------------------------------------------------------------
    always_comb
    begin
        cmd.ready        = 1'b0;
        gray_start       = 1'b0;
        ram_we           = 1'b0;
        rsp_load         = 1'b0;
        level_next       = level_reg;
        offset_next      = offset_reg;
        moving_down_next = moving_down_reg;
        unique case (state_reg)
            gpff_pkg::FS_IDLE:
            begin
                cmd.ready  = 1'b1;
                gray_start = cmd_fire && (opcode == gpff_pkg::OP_LOAD);
                if (cmd_fire)
                begin
                    level_next = '0;
                end
            end
            gpff_pkg::FS_LOAD:
            begin
                if (gray.done)
                begin
                    ram_we     = 1'b1;
                    level_next = gray.level;
                end
            end
            gpff_pkg::FS_TICK:
            begin
                offset_next      = gpff_pkg::OFFSET_W'(tick_clamped);
                moving_down_next = tick_down;
            end
            gpff_pkg::FS_READ:
            begin
                level_next = read_level;
            end
            gpff_pkg::FS_EMIT:
            begin
                rsp_load = rsp_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= gpff_pkg::FS_IDLE;
            offset_reg      <= '0;
            moving_down_reg <= 1'b1;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            offset_reg      <= offset_next;
            moving_down_reg <= moving_down_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg <= level_next;
        if (cmd_fire)
        begin
            idx_reg <= gpff_pkg::IDX_TABLE[cmd.entry_index];
        end
        if (rsp_load)
        begin
            rsp_level_reg  <= level_reg;
            rsp_offset_reg <= offset_reg;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.level_out  = rsp_level_reg;
    assign rsp.offset_out = rsp_offset_reg;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= gpff_pkg::FOG_STEP_RST;
            upper_reg <= gpff_pkg::UPPER_RST;
            lower_reg <= gpff_pkg::LOWER_RST;
        end
        else if (cfg_write)
        begin
            unique case (gpff_pkg::reg_index_t'(paddr[3:2]))
                gpff_pkg::REG_FOG_STEP:    step_reg  <= pwdata[gpff_pkg::STEP_W-1:0];
                gpff_pkg::REG_UPPER_LIMIT: upper_reg <= pwdata[gpff_pkg::LIMIT_W-1:0];
                gpff_pkg::REG_LOWER_LIMIT: lower_reg <= pwdata[gpff_pkg::LIMIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (gpff_pkg::reg_index_t'(paddr[3:2]))
            gpff_pkg::REG_FOG_STEP:    prdata = gpff_pkg::APB_DATA_W'(step_reg);
            gpff_pkg::REG_UPPER_LIMIT: prdata = gpff_pkg::APB_DATA_W'(upper_reg);
            gpff_pkg::REG_LOWER_LIMIT: prdata = gpff_pkg::APB_DATA_W'(lower_reg);
            default:                   prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for gray_palette_fog_fader_unit. A directed table walks
// the field extremes, every opcode, limit clamping and crossed limits. Random
// phases then run under several register settings. Every response is checked
// against its typed row or a cycle-free model of palette and bouncing offset.
// ----------------------------------------------------------------------------
module tb;
    import gpff_pkg::*;

    localparam int RUN_LIMIT  = 1_200_000;
    localparam int PHASES     = 8;
    localparam int PHASE_CMDS = 138;
    localparam int HOLD_LEN   = 300;
    localparam int SETTLE     = 20;
    localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;

    typedef enum bit {ROW_CMD, ROW_REG} row_kind_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [7:0]          index;
        logic [COLOR_W-1:0]  red;
        logic [COLOR_W-1:0]  green;
        logic [COLOR_W-1:0]  blue;
    } cmd_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]         level;
        logic signed [OFFSET_W-1:0] offset;
    } shade_t;

    typedef struct packed {
        row_kind_t           kind;
        logic [OPCODE_W-1:0] opcode;
        logic [7:0]          index;
        logic [7:0]          red;
        logic [7:0]          green;
        logic [7:0]          blue;
        reg_index_t          reg_sel;
        int                  reg_value;
        bit                  typed;
        logic [7:0]          exp_level;
        int                  exp_offset;
    } stim_row_t;

    // kind, opcode, index, r, g, b, register, value, typed, level, offset
    stim_row_t directed_rows [29] = '{
        '{ROW_CMD, OP_TICK,  8'd0,   8'd0,   8'd0,   8'd0,   REG_FOG_STEP, 0, 1, 8'd0, -4},
        '{ROW_CMD, OP_LOAD,  8'd0,   8'd0,   8'd0,   8'd0,   REG_FOG_STEP, 0, 1, 8'd0, -4},
        '{ROW_CMD, OP_LOAD,  8'd255, 8'd255, 8'd255, 8'd255, REG_FOG_STEP, 0, 1, 8'd255, -4},
        '{ROW_CMD, OP_READ,  8'd0,   8'd0,   8'd0,   8'd0,   REG_FOG_STEP, 0, 1, 8'd0, -4},
        '{ROW_CMD, OP_READ,  8'd255, 8'd0,   8'd0,   8'd0,   REG_FOG_STEP, 0, 1, 8'd251, -4},
        '{ROW_CMD, OP_LOAD,  8'd1,   8'd255, 8'd0,   8'd0,   REG_FOG_STEP, 0, 0, 8'd0, 0},
        '{ROW_CMD, OP_LOAD,  8'd2,   8'd0,   8'd255, 8'd0,   REG_FOG_STEP, 0, 0, 8'd0, 0},
        '{ROW_CMD, OP_LOAD,  8'd3,   8'd0,   8'd0,   8'd255, REG_FOG_STEP, 0, 0, 8'd0, 0},
        '{ROW_CMD, OP_LOAD,  8'd170, 8'd170, 8'd85,  8'd85,  REG_FOG_STEP, 0, 0, 8'd0, 0},
        '{ROW_CMD, OP_LOAD,  8'd85,  8'd85,  8'd170, 8'd170, REG_FOG_STEP, 0, 0, 8'd0, 0},
        '{ROW_CMD, OP_READ,  8'd170, 8'd0,   8'd0,   8'd0,   REG_FOG_STEP, 0, 0, 8'd0, 0},
        '{ROW_CMD, OP_SPARE, 8'd0,   8'd255, 8'd255, 8'd255, REG_FOG_STEP, 0, 1, 8'd0, -4},
        '{ROW_REG, OP_LOAD,  8'd0,   8'd0,   8'd0,   8'd0,   REG_FOG_STEP, 255, 0, 8'd0, 0},
        '{ROW_CMD, OP_TICK,  8'd0,   8'd0,   8'd0,   8'd0,   REG_FOG_STEP, 0, 1, 8'd0, -64},
        '{ROW_CMD, OP_TICK,  8'd0,   8'd0,   8'd0,   8'd0,   REG_FOG_STEP, 0, 1, 8'd0, 64},
        '{ROW_CMD, OP_READ,  8'd255, 8'd0,   8'd0,   8'd0,   REG_FOG_STEP, 0, 1, 8'd255, 64},
        '{ROW_REG, OP_LOAD,  8'd0,   8'd0,   8'd0,   8'd0,   REG_UPPER_LIMIT, 255, 0, 8'd0, 0},
        '{ROW_REG, OP_LOAD,  8'd0,   8'd0,   8'd0,   8'd0,   REG_LOWER_LIMIT, -255, 0, 8'd0, 0},
        '{ROW_CMD, OP_TICK,  8'd0,   8'd0,   8'd0,   8'd0,   REG_FOG_STEP, 0, 1, 8'd0, -191},
        '{ROW_CMD, OP_TICK,  8'd0,   8'd0,   8'd0,   8'd0,   REG_FOG_STEP, 0, 1, 8'd0, -255},
        '{ROW_CMD, OP_READ,  8'd255, 8'd0,   8'd0,   8'd0,   REG_FOG_STEP, 0, 1, 8'd0, -255},
        '{ROW_CMD, OP_TICK,  8'd0,   8'd0,   8'd0,   8'd0,   REG_FOG_STEP, 0, 1, 8'd0, 0},
        '{ROW_CMD, OP_TICK,  8'd0,   8'd0,   8'd0,   8'd0,   REG_FOG_STEP, 0, 1, 8'd0, 255},
        '{ROW_CMD, OP_TICK,  8'd0,   8'd0,   8'd0,   8'd0,   REG_FOG_STEP, 0, 1, 8'd0, 255},
        '{ROW_REG, OP_LOAD,  8'd0,   8'd0,   8'd0,   8'd0,   REG_UPPER_LIMIT, -255, 0, 8'd0, 0},
        '{ROW_REG, OP_LOAD,  8'd0,   8'd0,   8'd0,   8'd0,   REG_LOWER_LIMIT, 255, 0, 8'd0, 0},
        '{ROW_CMD, OP_TICK,  8'd0,   8'd0,   8'd0,   8'd0,   REG_FOG_STEP, 0, 1, 8'd0, 255},
        '{ROW_REG, OP_LOAD,  8'd0,   8'd0,   8'd0,   8'd0,   REG_FOG_STEP, 0, 0, 8'd0, 0},
        '{ROW_CMD, OP_TICK,  8'd0,   8'd0,   8'd0,   8'd0,   REG_FOG_STEP, 0, 1, 8'd0, 255}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    gpff_cmd_if cmd_if ();
    gpff_rsp_if rsp_if ();

    gray_palette_fog_fader_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_if),
        .rsp     (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Palette model state and register copies
    logic [LEVEL_W-1:0]        gray_palette [ENTRIES];
    bit                        palette_loaded [ENTRIES];
    int                        loaded_entries [$];
    int                        fade_offset = 0;
    bit                        fading_down = 1'b1;
    logic [STEP_W-1:0]         fog_step_cfg = 8'd4;
    logic signed [LIMIT_W-1:0] upper_cfg = 9'sd64;
    logic signed [LIMIT_W-1:0] lower_cfg = -9'sd64;

    shade_t shade_queue [$];
    shade_t next_shade;

    int err_count  = 0;
    int rsp_count  = 0;
    int reg_writes = 0;
    int op_seen [4] = '{0, 0, 0, 0};
    int burst_left = 0;

    // Receiver stall control
    int       stall_asks  = 0;
    int       stall_seen  = 0;
    int       hold_cycles = 0;
    bit [6:0] rx_count    = 7'd0;
    int       rx_mode     = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [LEVEL_W-1:0] gray_level(input cmd_t c);
        int mean_sq;
        int root;
        mean_sq = (int'(c.red) * int'(c.red) + int'(c.green) * int'(c.green)
                   + int'(c.blue) * int'(c.blue)) / 3;
        root = 0;
        while ((root + 1) * (root + 1) <= mean_sq)
            root++;
        return LEVEL_W'(root);
    endfunction

    function automatic shade_t predict_shade(input cmd_t c);
        shade_t s;
        int     v;
        s.level = '0;
        case (c.opcode)
            OP_LOAD:
            begin
                s.level = gray_level(c);
                gray_palette[c.index] = s.level;
                if (!palette_loaded[c.index])
                begin
                    palette_loaded[c.index] = 1'b1;
                    loaded_entries.push_back(int'(c.index));
                end
            end
            OP_TICK:
            begin
                v = fading_down ? fade_offset - int'(fog_step_cfg)
                                : fade_offset + int'(fog_step_cfg);
                if (v > int'(upper_cfg))
                begin
                    v = int'(upper_cfg);
                    fading_down = 1'b1;
                end
                if (v < int'(lower_cfg))
                begin
                    v = int'(lower_cfg);
                    fading_down = 1'b0;
                end
                fade_offset = v;
            end
            OP_READ:
            begin
                v = int'(gray_palette[c.index]) + fade_offset;
                if (v > 255)
                    v = 255;
                if (v < 0)
                    v = 0;
                s.level = LEVEL_W'(v);
            end
            default: ;
        endcase
        s.offset = OFFSET_W'(fade_offset);
        return s;
    endfunction

    function automatic logic [COLOR_W-1:0] pick_channel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return COLOR_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t c;
        int   pick;
        c.index = 8'($urandom_range(0, 255));
        c.red   = pick_channel();
        c.green = pick_channel();
        c.blue  = pick_channel();
        pick = $urandom_range(0, 99);
        if (pick < 30 || (pick < 95 && pick >= 60 && loaded_entries.size() == 0))
            c.opcode = OP_LOAD;
        else if (pick < 60)
            c.opcode = OP_TICK;
        else if (pick < 95)
        begin
            c.opcode = OP_READ;
            c.index  = 8'(loaded_entries[$urandom_range(0, loaded_entries.size() - 1)]);
        end
        else
            c.opcode = OP_SPARE;
        return c;
    endfunction

    task automatic send_cmd(input cmd_t c, input bit typed, input shade_t typed_shade);
        shade_t s;
        cmd_if.valid       <= 1'b1;
        cmd_if.opcode      <= c.opcode;
        cmd_if.entry_index <= c.index;
        cmd_if.red_in      <= c.red;
        cmd_if.green_in    <= c.green;
        cmd_if.blue_in     <= c.blue;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        s = predict_shade(c);
        shade_queue.push_back(typed ? typed_shade : s);
        op_seen[c.opcode]++;
        // end of burst: drop valid for a random gap, then pick the next burst
        if (burst_left == 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 90)
                                                      : $urandom_range(1, 24);
        end
        else
            burst_left--;
    endtask

    task automatic drain_and_pause();
        cmd_if.valid <= 1'b0;
        while (shade_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t which, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(which) << 2;
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // return the bus to idle between back-to-back writes
        @(posedge clk);
        case (which)
            REG_FOG_STEP:    fog_step_cfg = STEP_W'(value);
            REG_UPPER_LIMIT: upper_cfg    = LIMIT_W'(value);
            REG_LOWER_LIMIT: lower_cfg    = LIMIT_W'(value);
            default: ;
        endcase
        reg_writes++;
    endtask

    // Receiver: redraw ready pattern at rx_count wrap; honor long hold requests
    always @(posedge clk)
    begin
        rx_count <= rx_count + 7'd1;
        if (rx_count == 7'd0)
            rx_mode <= $urandom_range(0, 3);
        if (hold_cycles != 0)
        begin
            rsp_if.ready <= 1'b0;
            hold_cycles  <= hold_cycles - 1;
        end
        else if (stall_seen != stall_asks)
        begin
            stall_seen   <= stall_asks;
            hold_cycles  <= HOLD_LEN;
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                0: rsp_if.ready <= 1'b1;
                1: rsp_if.ready <= 1'($urandom_range(0, 1));
                2: rsp_if.ready <= ($urandom_range(0, 7) != 0);
                default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (shade_queue.size() == 0)
            begin
                $error("unexpected transaction: level_out %0d offset_out %0d",
                       rsp_if.level_out, rsp_if.offset_out);
                err_count++;
            end
            else
            begin
                next_shade = shade_queue.pop_front();
                rsp_count++;
                if (rsp_if.level_out !== next_shade.level)
                begin
                    $error("level_out: expected %0d, got %0d",
                           next_shade.level, rsp_if.level_out);
                    err_count++;
                end
                if (rsp_if.offset_out !== next_shade.offset)
                begin
                    $error("offset_out: expected %0d, got %0d",
                           next_shade.offset, rsp_if.offset_out);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        stim_row_t row;
        cmd_t      c;
        shade_t    typed_shade;
        int        step_val;
        int        upper_val;
        int        lower_val;

        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        cmd_if.valid       <= 1'b0;
        cmd_if.opcode      <= '0;
        cmd_if.entry_index <= '0;
        cmd_if.red_in      <= '0;
        cmd_if.green_in    <= '0;
        cmd_if.blue_in     <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_REG)
            begin
                drain_and_pause();
                write_reg(row.reg_sel, row.reg_value);
            end
            else
            begin
                c = '{row.opcode, row.index, row.red, row.green, row.blue};
                typed_shade = '{row.exp_level, OFFSET_W'(row.exp_offset)};
                send_cmd(c, row.typed, typed_shade);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin step_val = 4;   upper_val = 64;   lower_val = -64;  end
                1: begin step_val = 255; upper_val = 255;  lower_val = -255; end
                2: begin step_val = 1;   upper_val = 255;  lower_val = -255; end
                3: begin step_val = 0;   upper_val = 10;   lower_val = -10;  end
                4: begin step_val = 37;  upper_val = -100; lower_val = 100;  end
                7: begin step_val = 128; upper_val = 0;    lower_val = 0;    end
                default:
                begin
                    step_val  = $urandom_range(1, 64);
                    upper_val = $urandom_range(0, 255);
                    lower_val = -$urandom_range(0, 255);
                end
            endcase
            drain_and_pause();
            write_reg(REG_FOG_STEP, step_val);
            write_reg(REG_UPPER_LIMIT, upper_val);
            write_reg(REG_LOWER_LIMIT, lower_val);
            // hold the response side off while commands keep coming
            if (p == 1 || p == 5)
                stall_asks++;
            for (int n = 0; n < PHASE_CMDS; n++)
                send_cmd(random_cmd(), 1'b0, '0);
        end

        drain_and_pause();
        repeat (SETTLE) @(posedge clk);
        $display("Covered %0d loads, %0d ticks, %0d reads, %0d spare-opcode commands",
                 op_seen[OP_LOAD], op_seen[OP_TICK], op_seen[OP_READ], op_seen[OP_SPARE]);
        $display("%0d responses checked, %0d register writes, %0d palette entries loaded",
                 rsp_count, reg_writes, loaded_entries.size());
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("Timeout with %0d responses outstanding", shade_queue.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
